// ===== rtl/core/pip_pkg.sv =====
// Shared definitions for the point-in-polygon tester: field widths, action codes
// and the microcode program that sequences a query. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

   localparam int PIP_MAX_VERTICES = 64;
   localparam int PIP_MIN_VERTICES = 3;
   localparam int PIP_COORD_W      = 32;

   typedef logic [1:0]             action_type;
   typedef logic [PIP_COORD_W-1:0] coord_type;

   localparam action_type ACT_CLEAR  = 2'd0;
   localparam action_type ACT_APPEND = 2'd1;
   localparam action_type ACT_TEST   = 2'd2;

   // Sequencer step numbers.
   localparam int UC_PCW = 3;
   typedef logic [UC_PCW-1:0] uc_pc_type;

   localparam uc_pc_type U_IDLE   = 3'd0;
   localparam uc_pc_type U_RDLAST = 3'd1;
   localparam uc_pc_type U_LOADJ  = 3'd2;
   localparam uc_pc_type U_EDGE   = 3'd3;
   localparam uc_pc_type U_MUL    = 3'd4;
   localparam uc_pc_type U_CMP    = 3'd5;
   localparam uc_pc_type U_RESP   = 3'd6;

   // Jump conditions.
   typedef logic [1:0] uc_cond_type;
   localparam uc_cond_type C_NEXT     = 2'd0;
   localparam uc_cond_type C_DISPATCH = 2'd1;
   localparam uc_cond_type C_LOOP     = 2'd2;
   localparam uc_cond_type C_HOLD     = 2'd3;

   typedef struct packed {
      logic        accept;     // input channel is ready
      logic        sel_last;   // read address is the last stored vertex
      logic        clr;        // clear edge index and crossing parity
      logic        ld_j;       // load previous vertex from read data
      logic        edge_step;  // form differences of the current edge
      logic        mul_en;     // form both cross products
      logic        cmp_en;     // compare products, toggle parity
      logic        out_en;     // load the result register
      uc_cond_type cond;
      uc_pc_type   target;
   } uc_word_type;

   function automatic uc_word_type uc_rom(input uc_pc_type pc);
      uc_word_type w;
      w = '0;
      case (pc)
         U_IDLE: begin
            w.accept = 1'b1; w.cond = C_DISPATCH; w.target = U_RDLAST;
         end
         U_RDLAST: begin
            w.sel_last = 1'b1; w.clr = 1'b1; w.cond = C_NEXT;
         end
         U_LOADJ: begin
            w.ld_j = 1'b1; w.cond = C_NEXT;
         end
         U_EDGE: begin
            w.edge_step = 1'b1; w.cond = C_NEXT;
         end
         U_MUL: begin
            w.mul_en = 1'b1; w.cond = C_NEXT;
         end
         U_CMP: begin
            w.cmp_en = 1'b1; w.cond = C_LOOP; w.target = U_EDGE;
         end
         U_RESP: begin
            w.out_en = 1'b1; w.cond = C_HOLD; w.target = U_IDLE;
         end
         default: begin
            w.cond = C_HOLD; w.target = U_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pip_if.sv =====
// Valid/ready channel interfaces for the point-in-polygon tester: request
// (action and coordinates) and response (inside and degenerate flags). Uses pip_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pip_req_if;
   import pip_pkg::*;
   logic       valid;
   logic       ready;
   action_type action;
   coord_type  coord_x;
   coord_type  coord_y;
   modport source (output valid, output action, output coord_x, output coord_y,
                   input ready);
   modport sink   (input valid, input action, input coord_x, input coord_y,
                   output ready);
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic degenerate;
   modport source (output valid, output inside_res, output degenerate, input ready);
   modport sink   (input valid, input inside_res, input degenerate, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/point_in_polygon_test.sv =====
// Point-in-polygon tester: vertex store, microcoded edge walker, result register.
// Clear and append beats are taken one per cycle while the sequencer is idle and give no response.
// A test with n >= 3 vertices reads the last vertex as the previous one, then walks the
// edges with three sequencer steps per edge (edge, multiply, compare) before responding.
// A test with fewer than three vertices goes straight to the response step and is flagged degenerate.
// Synchronous reset empties the polygon and the response register; store contents persist.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test #(
   parameter int MAX_VERTICES = pip_pkg::PIP_MAX_VERTICES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pip_req_if.sink    req_bus,
   pip_rsp_if.source  rsp_bus
);
   import pip_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   uc_pc_type   pc_ff, pc_in;
   uc_word_type uw;

   logic [CW-1:0] count_ff, i_ff, cnt_m1;
   logic [AW-1:0] rd_addr;

   logic [PIP_COORD_W-1:0] mem_x [MAX_VERTICES];
   logic [PIP_COORD_W-1:0] mem_y [MAX_VERTICES];
   logic signed [31:0] rd_x_ff, rd_y_ff, xj_ff, yj_ff, px_ff, py_ff;

   logic signed [32:0] dif_a, dif_b, dif_c, dif_d;
   logic [31:0] ma_ff, mb_ff, mc_ff, md_ff;
   logic        sa_ff, sb_ff, sc_ff, sd_ff, st_ff, dpos_ff;
   logic [63:0] pl_ff, pr_ff;
   logic        pst_ff, pdpos_ff, pnl_ff, pnr_ff;
   logic        nl, nr, hit;

   logic inside_ff, degen_ff;
   logic rsp_valid_ff, rsp_inside_ff, rsp_degen_ff;
   logic fire, is_test, few, out_free, out_load, full;

   function automatic logic [31:0] mag32(input logic signed [32:0] v);
      logic [32:0] a;
      a = v[32] ? -v : v;
      return a[31:0];
   endfunction

   // Signed compare of two sign-and-magnitude values: a below b.
   function automatic logic lt(input logic na, input logic [63:0] ma,
                               input logic nb, input logic [63:0] mb);
      logic r;
      if (na != nb) begin
         r = na;
      end else if (na) begin
         r = ma > mb;
      end else begin
         r = ma < mb;
      end
      return r;
   endfunction

   assign uw       = uc_rom(pc_ff);
   assign fire     = req_bus.valid && uw.accept;
   assign is_test  = req_bus.action == ACT_TEST;
   assign few      = count_ff < CW'(PIP_MIN_VERTICES);
   assign full     = count_ff == CW'(MAX_VERTICES);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign out_load = uw.out_en && out_free;
   assign cnt_m1   = count_ff - CW'(1);
   assign rd_addr  = uw.sel_last ? cnt_m1[AW-1:0] : i_ff[AW-1:0];

   assign req_bus.ready      = uw.accept;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.inside_res = rsp_inside_ff;
   assign rsp_bus.degenerate = rsp_degen_ff;

   always_comb begin
      pc_in = pc_ff;
      case (uw.cond)
         C_NEXT:     pc_in = pc_ff + UC_PCW'(1);
         C_DISPATCH: if (fire && is_test) begin
            pc_in = few ? U_RESP : uw.target;
         end
         C_LOOP:     pc_in = (i_ff < count_ff) ? uw.target : pc_ff + UC_PCW'(1);
         C_HOLD:     if (out_free) begin
            pc_in = uw.target;
         end
         default:    pc_in = U_IDLE;
      endcase
   end

   // Vertex store, one write port for appends, one registered read port.
   always_ff @(posedge clock) begin
      if (fire && req_bus.action == ACT_APPEND && !full) begin
         mem_x[count_ff[AW-1:0]] <= req_bus.coord_x;
         mem_y[count_ff[AW-1:0]] <= req_bus.coord_y;
      end
      rd_x_ff <= $signed(mem_x[rd_addr]);
      rd_y_ff <= $signed(mem_y[rd_addr]);
   end

   assign dif_a = {px_ff[31], px_ff} - {rd_x_ff[31], rd_x_ff};
   assign dif_b = {xj_ff[31], xj_ff} - {rd_x_ff[31], rd_x_ff};
   assign dif_c = {py_ff[31], py_ff} - {rd_y_ff[31], rd_y_ff};
   assign dif_d = {yj_ff[31], yj_ff} - {rd_y_ff[31], rd_y_ff};

   // A zero product carries no sign.
   assign nl  = (pnl_ff) && (pl_ff != 64'd0);
   assign nr  = (pnr_ff) && (pr_ff != 64'd0);
   assign hit = pst_ff && (pdpos_ff ? lt(nl, pl_ff, nr, pr_ff) : lt(nr, pr_ff, nl, pl_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= U_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         if (fire) begin
            case (req_bus.action)
               ACT_CLEAR:  count_ff <= '0;
               ACT_APPEND: if (!full) begin
                  count_ff <= count_ff + CW'(1);
               end
               default:    count_ff <= count_ff;
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_test) begin
         px_ff     <= $signed(req_bus.coord_x);
         py_ff     <= $signed(req_bus.coord_y);
         degen_ff  <= few;
         inside_ff <= 1'b0;
      end
      if (uw.clr) begin
         i_ff      <= '0;
         inside_ff <= 1'b0;
      end
      if (uw.ld_j) begin
         xj_ff <= rd_x_ff;
         yj_ff <= rd_y_ff;
      end
      if (uw.edge_step) begin
         ma_ff   <= mag32(dif_a);
         mb_ff   <= mag32(dif_b);
         mc_ff   <= mag32(dif_c);
         md_ff   <= mag32(dif_d);
         sa_ff   <= dif_a[32];
         sb_ff   <= dif_b[32];
         sc_ff   <= dif_c[32];
         sd_ff   <= dif_d[32];
         st_ff   <= (rd_y_ff > py_ff) != (yj_ff > py_ff);
         dpos_ff <= !dif_d[32] && (dif_d != 33'sd0);
         xj_ff   <= rd_x_ff;
         yj_ff   <= rd_y_ff;
         i_ff    <= i_ff + CW'(1);
      end
      if (uw.mul_en) begin
         pl_ff    <= ma_ff * md_ff;
         pr_ff    <= mb_ff * mc_ff;
         pnl_ff   <= sa_ff ^ sd_ff;
         pnr_ff   <= sb_ff ^ sc_ff;
         pst_ff   <= st_ff;
         pdpos_ff <= dpos_ff;
      end
      if (uw.cmp_en && hit) begin
         inside_ff <= !inside_ff;
      end
      if (out_load) begin
         rsp_inside_ff <= inside_ff;
         rsp_degen_ff  <= degen_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count exceeds capacity");

   a_full_append: assert property (@(posedge clock) disable iff (reset)
      (fire && req_bus.action == ACT_APPEND && full) |=> $stable(count_ff))
      else $error("append to a full polygon changed the count");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && req_bus.action == ACT_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the polygon");

   a_loop_index: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == U_MUL || pc_ff == U_CMP) |-> (i_ff <= count_ff && i_ff != '0))
      else $error("edge index out of range during a test");

   a_degen_outside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_degen_ff) |-> !rsp_inside_ff)
      else $error("degenerate response reported inside");

endmodule

`default_nettype wire

// ===== tb/point_in_polygon_test_tb.sv =====
// Self-checking testbench for point_in_polygon_test: directed table, then random
// polygon sequences checked against an in-bench crossing-number predictor.
// Depends on pip_pkg and the pip_req_if / pip_rsp_if channel interfaces.
`timescale 1ns / 1ps

module point_in_polygon_test_tb;
   import pip_pkg::*;

   localparam action_type ACT_UNUSED = 2'd3;
   localparam int         DIR_ROWS   = 24;
   localparam int         PHASE_BEATS = 267;

   typedef struct {
      logic inside_res;
      logic degenerate;
   } verdict_type;

   typedef struct {
      action_type act;
      coord_type  x;
      coord_type  y;
      bit         typed;
      logic       inside_res;
      logic       degenerate;
   } stim_row_type;

   logic clock;
   logic reset;

   pip_req_if req_bus ();
   pip_rsp_if rsp_bus ();

   point_in_polygon_test DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // Polygon as the block should hold it.
   coord_type   poly_x [PIP_MAX_VERTICES];
   coord_type   poly_y [PIP_MAX_VERTICES];
   int unsigned poly_count = 0;

   verdict_type pending_verdicts [$];
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned phase_beats   = 0;
   int unsigned mismatches    = 0;

   // Triangle (0,0) (1,0) (0,1), then a square spanning the whole coordinate range.
   stim_row_type directed_rows [DIR_ROWS] = '{
      '{ACT_TEST,   32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b1},
      '{ACT_APPEND, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_APPEND, 32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h0000_4000, 32'h0000_4000, 1'b1, 1'b0, 1'b1},
      '{ACT_APPEND, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h0000_4000, 32'h0000_4000, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h0002_0000, 32'h0000_4000, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'hFFFF_0000, 32'h0000_4000, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h0000_4000, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h0000_4000, 32'h0000_4000, 1'b0, 1'b0, 1'b0},
      '{ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b1},
      '{ACT_APPEND, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{ACT_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
      '{ACT_TEST,   32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0},
      '{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0}
   };

   always #5 clock = ~clock;

   // Updates the polygon for one accepted beat and, for a test, gives the verdict.
   // Products need 66 bits: both factors are differences of 32-bit values (33 bits each).
   function automatic void apply_request(input action_type act, input coord_type x,
                                         input coord_type y, output bit has_rsp,
                                         output verdict_type v);
      logic signed [31:0] px, py, xi, yi, xj, yj;
      logic signed [33:0] dx_pt, dy_edge, dx_edge, dy_pt;
      logic signed [67:0] lhs, rhs;
      int unsigned        i, j;
      bit                 hit, parity;
      has_rsp      = 1'b0;
      v.inside_res = 1'b0;
      v.degenerate = 1'b0;
      case (act)
         ACT_CLEAR: begin
            poly_count = 0;
         end
         ACT_APPEND: begin
            if (poly_count < PIP_MAX_VERTICES) begin
               poly_x[poly_count] = x;
               poly_y[poly_count] = y;
               poly_count++;
            end
         end
         ACT_TEST: begin
            has_rsp = 1'b1;
            if (poly_count < PIP_MIN_VERTICES) begin
               v.degenerate = 1'b1;
            end else begin
               px     = x;
               py     = y;
               parity = 1'b0;
               j      = poly_count - 1;
               for (i = 0; i < poly_count; i++) begin
                  xi = poly_x[i];
                  yi = poly_y[i];
                  xj = poly_x[j];
                  yj = poly_y[j];
                  if ((yi > py) != (yj > py)) begin
                     dx_pt   = px - xi;
                     dy_edge = yj - yi;
                     dx_edge = xj - xi;
                     dy_pt   = py - yi;
                     lhs     = dx_pt * dy_edge;
                     rhs     = dx_edge * dy_pt;
                     // Multiplying through by the edge height flips the sense
                     // of the comparison when the edge runs downward.
                     hit = (dy_edge > 0) ? (lhs < rhs) : (rhs < lhs);
                     if (hit) parity = ~parity;
                  end
                  j = i;
               end
               v.inside_res = parity;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic coord_type rand_coord(input int unsigned scale);
      case (scale)
         0: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
         1: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
         default: begin
            if ($urandom_range(7) == 0) begin
               case ($urandom_range(3))
                  0: return 32'h8000_0000;
                  1: return 32'h7FFF_FFFF;
                  2: return 32'h0000_0000;
                  default: return 32'hFFFF_FFFF;
               endcase
            end
            return $urandom();
         end
      endcase
   endfunction

   // Query points often share a coordinate with a vertex or sit right next to one.
   function automatic void pick_query(input int unsigned scale, output coord_type qx,
                                      output coord_type qy);
      int unsigned idx;
      qx = rand_coord(scale);
      qy = rand_coord(scale);
      if (poly_count != 0) begin
         idx = $urandom_range(poly_count - 1);
         case ($urandom_range(3))
            1: qy = poly_y[idx];
            2: qx = poly_x[idx];
            3: begin
               qx = poly_x[idx] + $urandom_range(2) - 1;
               qy = poly_y[idx] + $urandom_range(2) - 1;
            end
            default: ;
         endcase
      end
   endfunction

   // Valid stays high from one beat to the next unless the sender idles.
   task automatic send_beat(input action_type act, input coord_type x, input coord_type y,
                            input bit typed, input logic t_inside, input logic t_degen);
      bit          has_rsp;
      verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.coord_x <= x;
      req_bus.coord_y <= y;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_request(act, x, y, has_rsp, v);
      if (has_rsp) begin
         if (typed) begin
            v.inside_res = t_inside;
            v.degenerate = t_degen;
         end
         pending_verdicts.push_back(v);
      end
      if (act != ACT_UNUSED) phase_beats++;
   endtask

   task automatic run_sequence();
      int unsigned kind, scale, nv, nt, k;
      coord_type   qx, qy;
      kind  = $urandom_range(99);
      scale = $urandom_range(2);
      if (kind < 80) begin
         // Mostly a fresh polygon; sometimes vertices pile onto the old one.
         if (kind < 72) send_beat(ACT_CLEAR, rand_coord(2), rand_coord(2), 0, 0, 0);
         nv = ($urandom_range(11) == 0) ? $urandom_range(60, 70) : $urandom_range(3, 10);
         for (k = 0; k < nv; k++)
            send_beat(ACT_APPEND, rand_coord(scale), rand_coord(scale), 0, 0, 0);
         nt = $urandom_range(1, 6);
         for (k = 0; k < nt; k++) begin
            pick_query(scale, qx, qy);
            send_beat(ACT_TEST, qx, qy, 0, 0, 0);
         end
      end else if (kind < 90) begin
         send_beat(ACT_CLEAR, rand_coord(2), rand_coord(2), 0, 0, 0);
         nv = $urandom_range(2);
         for (k = 0; k < nv; k++)
            send_beat(ACT_APPEND, rand_coord(scale), rand_coord(scale), 0, 0, 0);
         send_beat(ACT_TEST, rand_coord(scale), rand_coord(scale), 0, 0, 0);
      end else begin
         send_beat(action_type'($urandom_range(3)), rand_coord(2), rand_coord(2), 0, 0, 0);
      end
   endtask

   // Response side: check the beat taken at this edge, then pick next ready.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $error("response beat with no test pending: inside_res %0b degenerate %0b",
                   rsp_bus.inside_res, rsp_bus.degenerate);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_bus.inside_res !== want.inside_res) begin
               $error("inside_res: expected %0b, actual %0b", want.inside_res,
                      rsp_bus.inside_res);
               mismatches++;
            end
            if (rsp_bus.degenerate !== want.degenerate) begin
               $error("degenerate: expected %0b, actual %0b", want.degenerate,
                      rsp_bus.degenerate);
               mismatches++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      int unsigned r, k, phase;
      clock           = 1'b0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.action  <= ACT_CLEAR;
      req_bus.coord_x <= '0;
      req_bus.coord_y <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      rsp_idle_pct  = 57;
      for (r = 0; r < DIR_ROWS; r++)
         send_beat(directed_rows[r].act, directed_rows[r].x, directed_rows[r].y,
                   directed_rows[r].typed, directed_rows[r].inside_res,
                   directed_rows[r].degenerate);

      // Overfill the store; the extra vertices must be dropped.
      send_beat(ACT_CLEAR, 32'h0, 32'h0, 0, 0, 0);
      for (k = 0; k < PIP_MAX_VERTICES + 6; k++)
         send_beat(ACT_APPEND, rand_coord(0), rand_coord(0), 0, 0, 0);
      send_beat(ACT_TEST, 32'h0, 32'h0, 0, 0, 0);
      send_beat(ACT_TEST, rand_coord(0), rand_coord(0), 0, 0, 0);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 16; rsp_idle_pct = 57; end
            1: begin send_idle_pct = 57; rsp_idle_pct = 16; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         if (phase != 0) phase_beats = 0;
         while (phase_beats < PHASE_BEATS) run_sequence();
      end
      req_bus.valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (3 * PIP_MAX_VERTICES + 8) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
